// ===== design/hdc_pkg.sv =====
`default_nettype none

package hdc_pkg;

   localparam int MaxSizeDigitsDefault = 8;

   localparam int StatusWidth = 3;

   typedef struct packed {
      logic [StatusWidth-1:0] status;
      logic                   body_valid;
      logic [7:0]             body_byte;
   } hdc_result_type;

endpackage

`default_nettype wire

// ===== design/hdc_core.sv =====
`default_nettype none

module hdc_core #(
   parameter int MAX_SIZE_DIGITS = hdc_pkg::MaxSizeDigitsDefault
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  fire,
   input  wire logic [7:0]            rx_byte,
   input  wire logic                  pass_body,
   output hdc_pkg::hdc_result_type    result
);
   import hdc_pkg::*;

   localparam int CntWidth = $clog2(MAX_SIZE_DIGITS + 1);

   localparam logic [2:0] PhDigits = 3'd0;
   localparam logic [2:0] PhAfter  = 3'd1;
   localparam logic [2:0] PhData   = 3'd2;
   localparam logic [2:0] PhTerm   = 3'd3;
   localparam logic [2:0] PhTrail  = 3'd4;
   localparam logic [2:0] PhDone   = 3'd5;

   localparam logic [StatusWidth-1:0] StBusy    = 3'd0;
   localparam logic [StatusWidth-1:0] StDone    = 3'd1;
   localparam logic [StatusWidth-1:0] StTooLong = 3'd2;
   localparam logic [StatusWidth-1:0] StMissing = 3'd3;
   localparam logic [StatusWidth-1:0] StBadTerm = 3'd4;

   localparam logic [7:0] ByteLf = 8'h0a;
   localparam logic [7:0] ByteCr = 8'h0d;

   logic [2:0]             phase_ff, phase_in;
   logic [31:0]            remaining_ff, remaining_in;
   logic [CntWidth-1:0]    digit_count_ff, digit_count_in;
   logic                   line_start_ff, line_start_in;
   logic                   saw_cr_ff, saw_cr_in;
   logic [StatusWidth-1:0] fault_ff, fault_in;

   logic       is_hex;
   logic [3:0] hex_val;
   logic       after;

   always_comb begin
      is_hex  = 1'b1;
      hex_val = 4'd0;
      case (rx_byte) inside
         [8'h30:8'h39]: hex_val = 4'(rx_byte - 8'h30);
         [8'h41:8'h46]: hex_val = 4'(rx_byte - 8'h37);
         [8'h61:8'h66]: hex_val = 4'(rx_byte - 8'h57);
         default:       is_hex  = 1'b0;
      endcase
   end

   always_comb begin
      phase_in       = phase_ff;
      remaining_in   = remaining_ff;
      digit_count_in = digit_count_ff;
      line_start_in  = line_start_ff;
      saw_cr_in      = saw_cr_ff;
      fault_in       = fault_ff;
      after          = 1'b0;
      result         = '0;
      if (fault_ff != StBusy) begin
         result.status = fault_ff;
      end else begin
         case (phase_ff)
            PhDigits, PhAfter: begin
               after = (phase_ff == PhAfter);
               if (!after) begin
                  if (is_hex) begin
                     if (digit_count_ff < CntWidth'(MAX_SIZE_DIGITS)) begin
                        // saturate once a further shift would overflow
                        if (remaining_ff > 32'h0fff_ffff) begin
                           remaining_in = 32'hffff_ffff;
                        end else begin
                           remaining_in = {remaining_ff[27:0], hex_val};
                        end
                        digit_count_in = digit_count_ff + 1'b1;
                     end else begin
                        fault_in = StTooLong;
                     end
                  end else if (digit_count_ff == '0) begin
                     fault_in = StMissing;
                  end else begin
                     phase_in = PhAfter;
                     after    = 1'b1;
                  end
               end
               if (after && rx_byte == ByteLf) begin
                  if (remaining_in == 32'd0) begin
                     phase_in      = PhTrail;
                     line_start_in = 1'b1;
                     saw_cr_in     = 1'b0;
                  end else begin
                     phase_in = PhData;
                  end
               end
               result.status = fault_in;
            end
            PhData: begin
               if (pass_body) begin
                  result.body_byte  = rx_byte;
                  result.body_valid = 1'b1;
               end
               remaining_in = remaining_ff - 32'd1;
               if (remaining_ff == 32'd1) begin
                  phase_in = PhTerm;
               end
            end
            PhTerm: begin
               if (rx_byte == ByteLf) begin
                  phase_in       = PhDigits;
                  remaining_in   = 32'd0;
                  digit_count_in = '0;
               end else if (rx_byte != ByteCr) begin
                  fault_in = StBadTerm;
               end
               result.status = fault_in;
            end
            PhTrail: begin
               if (rx_byte == ByteLf) begin
                  if (line_start_ff || saw_cr_ff) begin
                     phase_in      = PhDone;
                     result.status = StDone;
                  end
                  line_start_in = 1'b1;
                  saw_cr_in     = 1'b0;
               end else begin
                  if (line_start_ff && rx_byte == ByteCr) begin
                     saw_cr_in = 1'b1;
                  end
                  line_start_in = 1'b0;
               end
            end
            default: begin
               result.status = StDone;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PhDigits;
         remaining_ff   <= 32'd0;
         digit_count_ff <= '0;
         line_start_ff  <= 1'b1;
         saw_cr_ff      <= 1'b0;
         fault_ff       <= StBusy;
      end else if (fire) begin
         phase_ff       <= phase_in;
         remaining_ff   <= remaining_in;
         digit_count_ff <= digit_count_in;
         line_start_ff  <= line_start_in;
         saw_cr_ff      <= saw_cr_in;
         fault_ff       <= fault_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/http_chunked_decoder.sv =====
// HTTP chunked body decoder, one received byte per request.
// req_*: raw body bytes, tdata[7:0] = rx_byte.
// rsp_*: exactly one response per request byte, in order:
//    tdata[7:0] body_byte, tdata[10:8] status, tuser body_valid.
//    status: 0 in progress, 1 complete, 2 size too long,
//    3 size missing, 4 bad data terminator (errors stick until reset).
// csr_*: pass_body write (bit 0); 0 drops data bytes instead of forwarding.
//    Write only while no request is in flight.
// The request byte is registered in the input register on acceptance, then
// decoded into the response register, which drives the response.
// Throughput: one byte per cycle while rsp_tready does not stall the
// response register, since the whole per-byte state update fits between the two
// registers and both registers advance together.
// Reset (synchronous) returns to the size line of the first chunk with
// pass_body = 1. When rsp_tready is low the response register holds and
// the input register keeps accepting until it is full; req_tready drops
// only when both stages are occupied.
`default_nettype none

module http_chunked_decoder #(
   parameter int MAX_SIZE_DIGITS = hdc_pkg::MaxSizeDigitsDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [15:0] rsp_tdata,   // [7:0] body_byte, [10:8] status, zeros
   output      logic        rsp_tuser,   // [0] body_valid
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [0:0]  csr_data     // [0] pass_body
);
   import hdc_pkg::*;

   logic           in_valid_ff, in_valid_in;
   logic [7:0]     in_byte_ff;
   logic           out_valid_ff, out_valid_in;
   hdc_result_type out_ff;
   hdc_result_type result;
   logic           pass_body_ff;
   logic           advance;
   logic           accept;

   assign advance     = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready  = !in_valid_ff || advance;
   assign accept      = req_tvalid && req_tready;
   assign in_valid_in = accept || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);
   assign csr_ready   = 1'b1;

   hdc_core #(
      .MAX_SIZE_DIGITS(MAX_SIZE_DIGITS)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .fire     (advance),
      .rx_byte  (in_byte_ff),
      .pass_body(pass_body_ff),
      .result   (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         pass_body_ff <= 1'b1;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_valid) begin
            pass_body_ff <= csr_data[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_tdata;
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'd0, out_ff.status, out_ff.body_byte};
   assign rsp_tuser  = out_ff.body_valid;

endmodule

`default_nettype wire
